/* sv/catr_pkg.sv */
// ----------------------------------------------------------------------------
// catr_pkg
// Shared types and codes for the coalescing access trace ring.
// ----------------------------------------------------------------------------
package catr_pkg;

    // Request codes
    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Action codes
    localparam logic [2:0] ACT_FILTERED = 3'd0;
    localparam logic [2:0] ACT_MERGED   = 3'd1;
    localparam logic [2:0] ACT_NEW      = 3'd2;
    localparam logic [2:0] ACT_HIT      = 3'd3;
    localparam logic [2:0] ACT_MISS     = 3'd4;
    localparam logic [2:0] ACT_CLEARED  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRACK_STACK = 2'd0;
    localparam logic [1:0] CFG_STACK_LOW   = 2'd1;
    localparam logic [1:0] CFG_STACK_HIGH  = 2'd2;

    localparam logic [15:0] STACK_LOW_RST  = 16'h2100;
    localparam logic [15:0] STACK_HIGH_RST = 16'h21FF;
    localparam logic [15:0] BYTES_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  bank;
        logic [15:0] bytes;
    } t_entry;

    typedef struct packed {
        logic        track;
        logic [15:0] low;
        logic [15:0] high;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] addr;
        logic [7:0]  bank;
        logic [5:0]  pos;
    } t_req;

    typedef struct packed {
        logic       vld;
        logic       from_mem;
        logic [2:0] action;
        t_entry     entry;
        logic [6:0] fill;
    } t_result;

endpackage

/* sv/catr_ring_mem.sv */
// ----------------------------------------------------------------------------
// catr_ring_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module catr_ring_mem #(
    parameter int ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  catr_pkg::t_entry           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output catr_pkg::t_entry           o_rdata
);
    import catr_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* sv/catr_ctrl.sv */
// ----------------------------------------------------------------------------
// catr_ctrl
// Ring state, filter and merge decision, result register.
// ----------------------------------------------------------------------------
module catr_ctrl #(
    parameter int ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  catr_pkg::t_req             i_req,
    input  catr_pkg::t_cfg             i_cfg,
    output logic                       o_we,
    output logic [$clog2(ENTRIES)-1:0] o_waddr,
    output catr_pkg::t_entry           o_wdata,
    output logic                       o_re,
    output logic [$clog2(ENTRIES)-1:0] o_raddr,
    output catr_pkg::t_result          o_res
);
    import catr_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int PW = ((AW > 6) ? AW : 6) + 1;
    localparam int FW = (CW > 7) ? CW : 7;

    logic [CW-1:0] r_filled, n_filled;
    logic [AW-1:0] r_wr_pos, n_wr_pos;
    logic [AW-1:0] r_last_pos, n_last_pos;
    logic          r_last_known, n_last_known;
    t_entry        r_last, n_last;
    t_result       r_res, n_res;

    logic          filt;
    logic          merge;
    logic [15:0]   merge_bytes;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] filled_w;
    logic [PW-1:0] sum_w;
    logic [PW-1:0] slot_w;
    logic [FW-1:0] fill_w;

    always_comb begin
        filt = !i_cfg.track && (i_req.addr >= i_cfg.low) && (i_req.addr <= i_cfg.high);
        merge = r_last_known && (r_last.bank == i_req.bank) &&
                (({1'b0, r_last.addr} + 17'd1 == {1'b0, i_req.addr}) ||
                 ({1'b0, i_req.addr} + 17'd1 == {1'b0, r_last.addr}));
        merge_bytes = (r_last.bytes == BYTES_MAX) ? BYTES_MAX : r_last.bytes + 16'd1;

        pos_w    = PW'(i_req.pos);
        filled_w = PW'(r_filled);
        sum_w    = PW'(r_wr_pos) + pos_w;
        slot_w   = (sum_w >= PW'(ENTRIES)) ? sum_w - PW'(ENTRIES) : sum_w;

        n_filled     = r_filled;
        n_wr_pos     = r_wr_pos;
        n_last_pos   = r_last_pos;
        n_last_known = r_last_known;
        n_last       = r_last;

        o_we    = 1'b0;
        o_waddr = r_wr_pos;
        o_wdata = '{addr: i_req.addr, bank: i_req.bank, bytes: 16'd1};
        o_re    = 1'b0;
        o_raddr = (r_filled < CW'(ENTRIES)) ? pos_w[AW-1:0] : slot_w[AW-1:0];

        n_res          = '0;
        n_res.action   = ACT_FILTERED;

        if (i_vld) begin
            unique case (i_req.req)
                REQ_RECORD: begin
                    n_res.vld = 1'b1;
                    if (filt) begin
                        n_res.action = ACT_FILTERED;
                    end else if (merge) begin
                        o_we          = 1'b1;
                        o_waddr       = r_last_pos;
                        o_wdata       = '{addr: i_req.addr, bank: r_last.bank,
                                          bytes: merge_bytes};
                        n_last        = o_wdata;
                        n_res.action  = ACT_MERGED;
                        n_res.entry   = o_wdata;
                    end else begin
                        o_we         = 1'b1;
                        n_filled     = (r_filled < CW'(ENTRIES)) ? r_filled + CW'(1)
                                                                  : r_filled;
                        n_last_pos   = r_wr_pos;
                        n_last_known = 1'b1;
                        n_wr_pos     = (r_wr_pos == AW'(ENTRIES - 1)) ? '0
                                                                       : r_wr_pos + AW'(1);
                        n_last       = o_wdata;
                        n_res.action = ACT_NEW;
                        n_res.entry  = o_wdata;
                    end
                end
                REQ_READ: begin
                    n_res.vld = 1'b1;
                    if (pos_w >= filled_w) begin
                        n_res.action = ACT_MISS;
                    end else begin
                        o_re           = 1'b1;
                        n_res.action   = ACT_HIT;
                        n_res.from_mem = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    n_res.vld    = 1'b1;
                    n_res.action = ACT_CLEARED;
                    n_filled     = '0;
                    n_wr_pos     = '0;
                    n_last_pos   = '0;
                    n_last_known = 1'b0;
                end
                default: begin
                    n_res.vld = 1'b0;
                end
            endcase
        end

        fill_w     = FW'(n_filled);
        n_res.fill = fill_w[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled     <= '0;
            r_wr_pos     <= '0;
            r_last_pos   <= '0;
            r_last_known <= 1'b0;
            r_res.vld    <= 1'b0;
        end else begin
            r_filled     <= n_filled;
            r_wr_pos     <= n_wr_pos;
            r_last_pos   <= n_last_pos;
            r_last_known <= n_last_known;
            r_res.vld    <= n_res.vld;
        end
        r_last            <= n_last;
        r_res.from_mem    <= n_res.from_mem;
        r_res.action      <= n_res.action;
        r_res.entry       <= n_res.entry;
        r_res.fill        <= n_res.fill;
    end

    assign o_res = r_res;

endmodule

/* sv/coalescing_access_trace_ring_core.sv */
// ----------------------------------------------------------------------------
// coalescing_access_trace_ring_core
// Accepted transactions pass the request register, then the result register.
// Throughput: one transaction per cycle; busy stays low, results cannot stall.
// Timing is set by the registered read port of the entry memory.
// Reset empties the ring and loads the configuration reset values; no
// clearing pass, unwritten entries are never read.
// ----------------------------------------------------------------------------
module coalescing_access_trace_ring_core #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_access_addr,
    input  logic [7:0]  i_access_bank,
    input  logic [5:0]  i_read_position,
    output logic        o_strobe,
    output logic [2:0]  o_action,
    output logic [15:0] o_item_addr,
    output logic [7:0]  o_item_bank,
    output logic [15:0] o_item_bytes,
    output logic [6:0]  o_fill_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import catr_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    t_cfg    r_cfg;
    logic    r_vld;
    t_req    r_req;
    logic    we;
    logic    re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_entry  wdata;
    t_entry  rdata;
    t_result res;
    t_entry  out_entry;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track <= 1'b0;
            r_cfg.low   <= STACK_LOW_RST;
            r_cfg.high  <= STACK_HIGH_RST;
            r_vld       <= 1'b0;
        end else begin
            r_vld <= start && !busy;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TRACK_STACK: r_cfg.track <= i_cfg_data[0];
                    CFG_STACK_LOW:   r_cfg.low   <= i_cfg_data;
                    CFG_STACK_HIGH:  r_cfg.high  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_req <= '{req: i_req_type, addr: i_access_addr, bank: i_access_bank,
                   pos: i_read_position};
    end

    catr_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_req   (r_req),
        .i_cfg   (r_cfg),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .o_res   (res)
    );

    catr_ring_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_entry    = res.from_mem ? rdata : res.entry;
    assign o_strobe     = res.vld;
    assign o_action     = res.action;
    assign o_item_addr  = out_entry.addr;
    assign o_item_bank  = out_entry.bank;
    assign o_item_bytes = out_entry.bytes;
    assign o_fill_count = res.fill;

endmodule
